>>> hdl/rc4_stream_cipher_core_macros.svh
// assertion macros shared by the rc4 checker
`ifndef RC4_STREAM_CIPHER_CORE_MACROS_SVH
`define RC4_STREAM_CIPHER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RC4_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc4 core check failed");

// next-cycle implication, sampled on clk, off during reset
`define RC4_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc4 core check failed");

`endif

>>> hdl/rc4_pkg.sv
// types, codes and microcode table of the rc4 stream cipher core
package rc4_pkg;

  // action codes of an input transaction
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SCHED = 2'd1;
  localparam logic [1:0] ACT_CRYPT = 2'd2;

  // result status codes
  localparam logic ST_DONE       = 1'b0;
  localparam logic ST_NOT_KEYED  = 1'b1;

  // register index bit of the config port
  localparam logic REG_KEY_LENGTH = 1'b0;

  // last entry of the permutation
  localparam logic [7:0] PERM_LAST = 8'hFF;

  // microcode step addresses
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 5'd0;
  localparam step_t STEP_LOAD   = 5'd1;
  localparam step_t STEP_NOP    = 5'd2;
  localparam step_t STEP_NOKEY  = 5'd3;
  localparam step_t STEP_S_CLR  = 5'd4;
  localparam step_t STEP_S_INIT = 5'd5;
  localparam step_t STEP_S_M0   = 5'd6;
  localparam step_t STEP_S_M1   = 5'd7;
  localparam step_t STEP_S_M2   = 5'd8;
  localparam step_t STEP_S_M3   = 5'd9;
  localparam step_t STEP_S_M4   = 5'd10;
  localparam step_t STEP_S_END  = 5'd11;
  localparam step_t STEP_C0     = 5'd12;
  localparam step_t STEP_C1     = 5'd13;
  localparam step_t STEP_C2     = 5'd14;
  localparam step_t STEP_C3     = 5'd15;
  localparam step_t STEP_C4     = 5'd16;
  localparam step_t STEP_C5     = 5'd17;
  localparam step_t STEP_C6     = 5'd18;

  // control word fields
  typedef enum logic [2:0] {
    ADDR_NONE, ADDR_I, ADDR_I_INC, ADDR_J, ADDR_T
  } addr_sel_t;

  typedef enum logic [1:0] {WD_I, WD_RDATA, WD_SA} wdata_sel_t;
  typedef enum logic [1:0] {I_HOLD, I_INC, I_CLEAR} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_CLEAR, J_ADD_PERM, J_ADD_PERM_KEY} j_op_t;
  typedef enum logic [1:0] {K_HOLD, K_CLEAR, K_STEP} k_op_t;
  typedef enum logic [1:0] {RES_NONE, RES_DONE, RES_NOKEY, RES_CRYPT} res_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP_I, SEQ_DONE} seq_t;

  typedef struct packed {
    addr_sel_t  addr_sel;
    logic       mem_we;
    wdata_sel_t wdata_sel;
    i_op_t      i_op;
    j_op_t      j_op;
    logic       sa_ld;
    logic       t_ld;
    k_op_t      k_op;
    logic       key_we;
    logic       set_keyed;
    res_t       res;
    seq_t       seq;
    step_t      target;
  } ctrl_t;

  // first step of each kind of transaction
  function automatic step_t entry_step(logic [1:0] action, logic keyed);
    step_t s;
    case (action)
      ACT_LOAD:  s = STEP_LOAD;
      ACT_SCHED: s = STEP_S_CLR;
      ACT_CRYPT: s = keyed ? STEP_C0 : STEP_NOKEY;
      default:   s = STEP_NOP;
    endcase
    return s;
  endfunction

  // microcode rom
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w.addr_sel  = ADDR_NONE;
    w.mem_we    = 1'b0;
    w.wdata_sel = WD_I;
    w.i_op      = I_HOLD;
    w.j_op      = J_HOLD;
    w.sa_ld     = 1'b0;
    w.t_ld      = 1'b0;
    w.k_op      = K_HOLD;
    w.key_we    = 1'b0;
    w.set_keyed = 1'b0;
    w.res       = RES_NONE;
    w.seq       = SEQ_NEXT;
    w.target    = STEP_IDLE;
    case (s)
      // key byte load
      STEP_LOAD: begin
        w.key_we = 1'b1;
        w.res    = RES_DONE;
        w.seq    = SEQ_DONE;
      end
      // unused action
      STEP_NOP: begin
        w.res = RES_DONE;
        w.seq = SEQ_DONE;
      end
      // crypt before any schedule
      STEP_NOKEY: begin
        w.res = RES_NOKEY;
        w.seq = SEQ_DONE;
      end
      // schedule: clear indices
      STEP_S_CLR: begin
        w.i_op = I_CLEAR;
        w.j_op = J_CLEAR;
        w.k_op = K_CLEAR;
      end
      // schedule: identity fill
      STEP_S_INIT: begin
        w.addr_sel  = ADDR_I;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_I;
        w.i_op      = I_INC;
        w.seq       = SEQ_LOOP_I;
        w.target    = STEP_S_INIT;
      end
      // schedule: read s[i]
      STEP_S_M0: begin
        w.addr_sel = ADDR_I;
      end
      // schedule: j += s[i] + key
      STEP_S_M1: begin
        w.j_op  = J_ADD_PERM_KEY;
        w.sa_ld = 1'b1;
        w.k_op  = K_STEP;
      end
      STEP_S_M2: begin
        w.addr_sel = ADDR_J;
      end
      STEP_S_M3: begin
        w.addr_sel  = ADDR_I;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_RDATA;
      end
      STEP_S_M4: begin
        w.addr_sel  = ADDR_J;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_SA;
        w.i_op      = I_INC;
        w.seq       = SEQ_LOOP_I;
        w.target    = STEP_S_M0;
      end
      STEP_S_END: begin
        w.j_op      = J_CLEAR;
        w.set_keyed = 1'b1;
        w.res       = RES_DONE;
        w.seq       = SEQ_DONE;
      end
      // crypt: i += 1, read s[i]
      STEP_C0: begin
        w.addr_sel = ADDR_I_INC;
        w.i_op     = I_INC;
      end
      STEP_C1: begin
        w.j_op  = J_ADD_PERM;
        w.sa_ld = 1'b1;
      end
      STEP_C2: begin
        w.addr_sel = ADDR_J;
      end
      // crypt: swap, form t
      STEP_C3: begin
        w.addr_sel  = ADDR_I;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_RDATA;
        w.t_ld      = 1'b1;
      end
      STEP_C4: begin
        w.addr_sel  = ADDR_J;
        w.mem_we    = 1'b1;
        w.wdata_sel = WD_SA;
      end
      STEP_C5: begin
        w.addr_sel = ADDR_T;
      end
      STEP_C6: begin
        w.res = RES_CRYPT;
        w.seq = SEQ_DONE;
      end
      default: begin
        w.seq = SEQ_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/rc4_stream_cipher_core.sv
// rc4 stream cipher core: microcoded sequencer over a single-port permutation memory
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | action, key_slot, data_byte, frame_end
//  out_    | output    | out_valid / out_stall  | byte, status, last_out
//  cfg     | input     | psel/penable/pwrite    | key_length at addresses 0-3 (paddr[2] = 0)
//
// one transaction at a time; in_stall is high from accept until the result is registered
// load, unused action and unkeyed crypt end at their entry step; crypt: 7 steps, set by the
// one access per cycle to the permutation memory; schedule: 256 fill steps and 5 steps
// per mix round, same memory port
// a finished result waits in the output register; the sequencer holds its last step
// while out_stall keeps that register full
// synchronous active-low reset clears indices and keyed flag and sets key_length to 256
module rc4_stream_cipher_core #(
  parameter int KEY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_key_slot,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_status,
  output logic        out_last_out,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [8:0] DEPTH_LEN = 9'(KEY_DEPTH);

  // sequencer and datapath registers
  rc4_pkg::step_t upc_r, upc_nxt;
  rc4_pkg::ctrl_t cw;
  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic [7:0]     t_r;
  logic [7:0]     sa_r;
  logic [KW-1:0]  kidx_r, kidx_nxt;
  logic           keyed_r;
  logic [8:0]     key_length_r;
  logic [8:0]     len_eff;
  logic           kidx_last;

  // latched transaction
  logic [1:0]     act_r;
  logic [7:0]     slot_r;
  logic [7:0]     data_r;
  logic           fend_r;

  // memories
  logic [7:0]     perm_mem [256];
  logic [7:0]     key_mem  [KEY_DEPTH];
  logic [7:0]     perm_addr;
  logic [7:0]     perm_wdata;
  logic           perm_rd;
  logic [7:0]     rdata_r;
  logic [7:0]     key_q_r;
  logic           key_wr;

  // output register
  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_status_r;
  logic           out_last_r;
  logic           out_free;
  logic           out_load;
  logic           in_accept;
  logic           cfg_wr;

  assign cw        = rc4_pkg::ucode(upc_r);
  assign in_stall  = (upc_r != rc4_pkg::STEP_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (cw.res != rc4_pkg::RES_NONE) && out_free;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rc4_pkg::REG_KEY_LENGTH);
  assign prdata = (paddr[2] == rc4_pkg::REG_KEY_LENGTH) ? {23'd0, key_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= 9'd256;
    end else if (cfg_wr) begin
      key_length_r <= pwdata[8:0];
    end
  end

  // key length in use: zero or oversize means the whole store
  always_comb begin
    if (key_length_r == 9'd0 || key_length_r > DEPTH_LEN) begin
      len_eff = DEPTH_LEN;
    end else begin
      len_eff = key_length_r;
    end
  end

  assign kidx_last = (9'(kidx_r) == (len_eff - 9'd1));

  // transaction latch
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r  <= in_action;
      slot_r <= in_key_slot;
      data_r <= in_data_byte;
      fend_r <= in_frame_end;
    end
  end

  // step counter with conditional jumps
  always_comb begin
    upc_nxt = upc_r;
    if (upc_r == rc4_pkg::STEP_IDLE) begin
      if (in_accept) begin
        upc_nxt = rc4_pkg::entry_step(in_action, keyed_r);
      end
    end else begin
      case (cw.seq)
        rc4_pkg::SEQ_NEXT:   upc_nxt = upc_r + 1'b1;
        rc4_pkg::SEQ_LOOP_I: upc_nxt = (i_r != rc4_pkg::PERM_LAST) ? cw.target : upc_r + 1'b1;
        rc4_pkg::SEQ_DONE:   upc_nxt = out_free ? rc4_pkg::STEP_IDLE : upc_r;
        default:             upc_nxt = rc4_pkg::STEP_IDLE;
      endcase
    end
  end

  // index updates
  always_comb begin
    case (cw.i_op)
      rc4_pkg::I_INC:   i_nxt = i_r + 8'd1;
      rc4_pkg::I_CLEAR: i_nxt = 8'd0;
      default:          i_nxt = i_r;
    endcase
    case (cw.j_op)
      rc4_pkg::J_CLEAR:        j_nxt = 8'd0;
      rc4_pkg::J_ADD_PERM:     j_nxt = j_r + rdata_r;
      rc4_pkg::J_ADD_PERM_KEY: j_nxt = j_r + rdata_r + key_q_r;
      default:                 j_nxt = j_r;
    endcase
    case (cw.k_op)
      rc4_pkg::K_CLEAR: kidx_nxt = '0;
      rc4_pkg::K_STEP:  kidx_nxt = kidx_last ? '0 : kidx_r + 1'b1;
      default:          kidx_nxt = kidx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= rc4_pkg::STEP_IDLE;
      i_r     <= 8'd0;
      j_r     <= 8'd0;
      kidx_r  <= '0;
      keyed_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      kidx_r <= kidx_nxt;
      if (cw.set_keyed) begin
        keyed_r <= 1'b1;
      end
    end
  end

  // swap operands
  always_ff @(posedge clk) begin
    if (cw.sa_ld) begin
      sa_r <= rdata_r;
    end
    if (cw.t_ld) begin
      t_r <= sa_r + rdata_r;
    end
  end

  // permutation port address and write data
  always_comb begin
    case (cw.addr_sel)
      rc4_pkg::ADDR_I_INC: perm_addr = i_r + 8'd1;
      rc4_pkg::ADDR_J:     perm_addr = j_r;
      rc4_pkg::ADDR_T:     perm_addr = t_r;
      default:             perm_addr = i_r;
    endcase
    case (cw.wdata_sel)
      rc4_pkg::WD_RDATA: perm_wdata = rdata_r;
      rc4_pkg::WD_SA:    perm_wdata = sa_r;
      default:           perm_wdata = i_r;
    endcase
  end

  assign perm_rd = (cw.addr_sel != rc4_pkg::ADDR_NONE) && !cw.mem_we;

  // permutation memory, one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (cw.mem_we) begin
      perm_mem[perm_addr] <= perm_wdata;
    end
    if (perm_rd) begin
      rdata_r <= perm_mem[perm_addr];
    end
  end

  // key store, slots past the store are dropped
  assign key_wr = cw.key_we && (act_r == rc4_pkg::ACT_LOAD) && ({1'b0, slot_r} < DEPTH_LEN);

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[slot_r[KW-1:0]] <= data_r;
    end
    key_q_r <= key_mem[kidx_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_last_r <= fend_r;
      case (cw.res)
        rc4_pkg::RES_CRYPT: begin
          out_byte_r   <= data_r ^ rdata_r;
          out_status_r <= rc4_pkg::ST_DONE;
        end
        rc4_pkg::RES_NOKEY: begin
          out_byte_r   <= 8'd0;
          out_status_r <= rc4_pkg::ST_NOT_KEYED;
        end
        default: begin
          out_byte_r   <= 8'd0;
          out_status_r <= rc4_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_status   = out_status_r;
  assign out_last_out = out_last_r;

endmodule

>>> hdl/rc4_checker.sv
// port-level checker for the rc4 stream cipher core and its bind
`include "rc4_stream_cipher_core_macros.svh"

module rc4_core_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_status,
  input logic       out_last_out
);

  // a stalled result keeps its transaction
  `RC4_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable({out_byte, out_status, out_last_out}))

  // an unkeyed crypt result carries a zero byte
  `RC4_ASSERT_IMP(a_nokey_zero, out_valid && (out_status == rc4_pkg::ST_NOT_KEYED), out_byte == 8'h00)

  // the core is busy right after taking a transaction
  `RC4_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a new result only comes out of a busy core
  `RC4_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind rc4_stream_cipher_core rc4_core_assertions u_rc4_checker (.*);

>>> bench/rc4_checker.sv
// rc4 core checker: keystream prediction and result comparison
`timescale 1ns / 1ps

module rc4_checker #(
  parameter int KEY_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_key_slot,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_status,
  input  logic        out_last_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } cipher_result_t;

  // mirrored cipher state
  logic [7:0] sbox [256];
  logic [7:0] key_bytes [KEY_SLOTS];
  logic [7:0] gen_i;
  logic [7:0] gen_j;
  logic       is_keyed;
  logic [8:0] key_len;

  cipher_result_t expected_q [$];
  cipher_result_t oldest;
  int             errors;

  // key scheduling from the identity permutation
  function automatic void schedule_key();
    int unsigned len;
    logic [7:0]  j;
    logic [7:0]  t;
    len = (key_len == 0 || key_len > KEY_SLOTS) ? KEY_SLOTS : key_len;
    for (int k = 0; k < 256; k++) sbox[k] = k[7:0];
    j = 8'h00;
    for (int k = 0; k < 256; k++) begin
      j = j + sbox[k] + key_bytes[k % len];
      t = sbox[k];
      sbox[k] = sbox[j];
      sbox[j] = t;
    end
    gen_i    = 8'h00;
    gen_j    = 8'h00;
    is_keyed = 1'b1;
  endfunction

  // one generator step with its swap
  function automatic logic [7:0] next_key_byte();
    logic [7:0] t;
    gen_i = gen_i + 8'd1;
    gen_j = gen_j + sbox[gen_i];
    t = sbox[gen_i];
    sbox[gen_i] = sbox[gen_j];
    sbox[gen_j] = t;
    t = sbox[gen_i] + sbox[gen_j];
    return sbox[t];
  endfunction

  function automatic cipher_result_t predict_cipher(logic [1:0] act, logic [7:0] slot,
                                                    logic [7:0] data, logic fend);
    cipher_result_t r;
    r.data   = 8'h00;
    r.status = rc4_pkg::ST_DONE;
    r.last   = fend;
    case (act)
      rc4_pkg::ACT_LOAD: begin
        if (slot < KEY_SLOTS) key_bytes[slot] = data;
      end
      rc4_pkg::ACT_SCHED: begin
        schedule_key();
      end
      rc4_pkg::ACT_CRYPT: begin
        if (is_keyed) r.data = data ^ next_key_byte();
        else r.status = rc4_pkg::ST_NOT_KEYED;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expv, actv);
    end
  endtask

  // watch config writes, accepted transactions and results
  always @(posedge clk) begin
    if (!rst_n) begin
      gen_i    = 8'h00;
      gen_j    = 8'h00;
      is_keyed = 1'b0;
      key_len  = 9'd256;
      errors   = 0;
      expected_q.delete();
      for (int k = 0; k < 256; k++) sbox[k] = 8'h00;
      for (int k = 0; k < KEY_SLOTS; k++) key_bytes[k] = 8'h00;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == {rc4_pkg::REG_KEY_LENGTH, 2'b00})
        key_len = pwdata[8:0];
      if (in_valid && !in_stall)
        expected_q.push_back(predict_cipher(in_action, in_key_slot, in_data_byte,
                                            in_frame_end));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, actual %02h/%0d/%0d",
                   $time, out_byte, out_status, out_last_out);
        end else begin
          oldest = expected_q.pop_front();
          compare_field("out_byte", oldest.data, out_byte);
          compare_field("out_status", oldest.status, out_status);
          compare_field("out_last_out", oldest.last, out_last_out);
        end
      end
    end
    error_count <= errors;
    pending     <= expected_q.size();
  end

endmodule

>>> bench/testbench.sv
// rc4 core testbench top: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int          KEY_SLOTS        = 256;
  localparam int          ITEM_TARGET      = 840;
  localparam int          TAIL_ITEMS       = 60;
  localparam int          LONG_HOLD_AT     = 300;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES     = 20;
  localparam int          CYCLE_LIMIT      = 600000;
  localparam logic [1:0]  ACT_UNUSED       = 2'd3;
  localparam logic [2:0]  KEY_LEN_ADDR     = {rc4_pkg::REG_KEY_LENGTH, 2'b00};
  localparam logic [2:0]  SPARE_ADDR       = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_key_slot;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_status;
  logic        out_last_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          error_count;
  int          pending;

  int          items_sent = 0;
  int          cycle_count;
  bit          sender_idles = 1'b1;
  bit          key_loaded [KEY_SLOTS];

  rc4_stream_cipher_core #(.KEY_DEPTH(KEY_SLOTS)) i_dut (.*);

  rc4_checker #(.KEY_SLOTS(KEY_SLOTS)) i_checker (.*);

  always #10 clk = ~clk;

  function automatic bit in_tail();
    return items_sent >= ITEM_TARGET - TAIL_ITEMS;
  endfunction

  // offer one transaction, with an occasional gap in front of it
  task automatic send_item(input logic [1:0] act, input logic [7:0] slot,
                           input logic [7:0] data, input logic fend);
    if (sender_idles && !in_tail() && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_key_slot  <= slot;
    in_data_byte <= data;
    in_frame_end <= fend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == rc4_pkg::ACT_LOAD) key_loaded[slot] = 1'b1;
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [8:0] value);
    logic [31:0] word;
    word      = $urandom();
    word[8:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // new key length, key fill, schedule, then one message with some noise
  task automatic run_phase(input logic [8:0] len);
    int unsigned eff;
    int unsigned msg_len;
    bit          fresh;
    wait_drained();
    reg_write(KEY_LEN_ADDR, len);
    eff   = (len == 0 || len > KEY_SLOTS) ? KEY_SLOTS : len;
    fresh = (eff <= 16) && ($urandom_range(0, 1) == 1);
    for (int s = 0; s < eff; s++)
      if (fresh || !key_loaded[s])
        send_item(rc4_pkg::ACT_LOAD, s[7:0], 8'($urandom()), 1'($urandom_range(0, 1)));
    send_item(rc4_pkg::ACT_SCHED, 8'($urandom()), 8'($urandom()),
              1'($urandom_range(0, 1)));
    msg_len = $urandom_range(1, 40);
    for (int n = 0; n < msg_len; n++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()),
                  1'($urandom_range(0, 1)));
      send_item(rc4_pkg::ACT_CRYPT, 8'($urandom()), 8'($urandom()),
                (n == msg_len - 1) && ($urandom_range(0, 9) != 0));
    end
  endtask

  // result side back-pressure
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!in_tail() && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned phase;
    logic [8:0]  len;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= rc4_pkg::ACT_LOAD;
    in_key_slot  <= 8'h00;
    in_data_byte <= 8'h00;
    in_frame_end <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= 3'd0;
    pwdata       <= 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // crypt before any schedule, unused action, top key slot
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'hFF, 1'b1);
    send_item(rc4_pkg::ACT_CRYPT, 8'hFF, 8'h00, 1'b0);
    send_item(ACT_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_item(rc4_pkg::ACT_LOAD, 8'hFF, 8'hFF, 1'b0);

    // three byte key; write to an unmapped register must not disturb it
    wait_drained();
    reg_write(KEY_LEN_ADDR, 9'd3);
    reg_write(SPARE_ADDR, 9'd1);
    send_item(rc4_pkg::ACT_LOAD, 8'd0, 8'h00, 1'b1);
    send_item(rc4_pkg::ACT_LOAD, 8'd1, 8'hFF, 1'b0);
    send_item(rc4_pkg::ACT_LOAD, 8'd2, 8'h5A, 1'b0);
    send_item(rc4_pkg::ACT_SCHED, 8'h00, 8'h00, 1'b0);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'h00, 1'b0);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'hFF, 1'b0);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'hA5, 1'b1);
    // frame end does not restart the generator
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'h5A, 1'b0);
    send_item(ACT_UNUSED, 8'h00, 8'h00, 1'b0);
    send_item(rc4_pkg::ACT_LOAD, 8'd0, 8'h80, 1'b1);
    send_item(rc4_pkg::ACT_CRYPT, 8'hFF, 8'h01, 1'b1);
    send_item(rc4_pkg::ACT_SCHED, 8'hFF, 8'hFF, 1'b1);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'hFF, 1'b0);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'h00, 1'b1);

    // single byte key
    wait_drained();
    reg_write(KEY_LEN_ADDR, 9'd1);
    send_item(rc4_pkg::ACT_SCHED, 8'h00, 8'h00, 1'b0);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'h3C, 1'b0);
    send_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'hC3, 1'b1);

    // random phases, key length extremes first
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      sender_idles = $urandom_range(0, 3) != 0;
      case (phase)
        0: len = 9'd0;
        1: len = 9'd256;
        2: len = 9'd511;
        3: len = 9'd257;
        4: len = 9'd1;
        default: begin
          if ($urandom_range(0, 7) == 0) len = 9'($urandom_range(17, 511));
          else len = 9'($urandom_range(1, 16));
        end
      endcase
      run_phase(len);
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rc4_pkg.sv
hdl/rc4_stream_cipher_core.sv
hdl/rc4_checker.sv
bench/rc4_checker.sv
bench/testbench.sv
